/* rtl/core/utli_pkg.sv */
// Shared constants for the unsorted-table linear interpolator.
package utli_pkg;

  localparam int DATA_W          = 32;
  localparam int TABLE_DEPTH_DEF = 64;
  localparam int INDEX_W         = 6;
  localparam int ACTIVE_W        = 7;
  localparam int STATUS_W        = 3;
  localparam int DIV_STEPS       = 32;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_INTERP = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_EXACT  = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_BELOW  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_ABOVE  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_EMPTY  = 3'd4;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

endpackage

/* rtl/core/utli_table.sv */
// Point store: x and y columns, one write port and one registered read port.
module utli_table import utli_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [ADDR_W-1:0]        wr_addr,
  input  logic signed [DATA_W-1:0] wr_x,
  input  logic signed [DATA_W-1:0] wr_y,
  input  logic [ADDR_W-1:0]        rd_addr,
  output logic signed [DATA_W-1:0] rd_x,
  output logic signed [DATA_W-1:0] rd_y
);

  logic signed [DATA_W-1:0] mem_x [TABLE_DEPTH];
  logic signed [DATA_W-1:0] mem_y [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= wr_x;
      mem_y[wr_addr] <= wr_y;
    end
  end

  always_ff @(posedge clk) begin
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
  end

endmodule

/* rtl/core/utli_div.sv */
// Restoring divider: 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
module utli_div import utli_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [2*DATA_W-1:0]   dividend,
  input  logic [DATA_W-1:0]     divisor,
  output logic                  done,
  output logic [DATA_W-1:0]     quotient
);

  localparam int CNT_W = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [DATA_W:0]   trial;
  logic              fits;

  // The caller guarantees the upper half of the dividend is below the divisor,
  // so the quotient fits in DATA_W bits and the remainder never needs more.
  assign trial = {rem_r, quo_r[DATA_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = dividend[2*DATA_W-1:DATA_W];
      quo_nxt = dividend[DATA_W-1:0];
      dvs_nxt = divisor;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = fits ? DATA_W'(trial - {1'b0, dvs_r}) : trial[DATA_W-1:0];
      quo_nxt = {quo_r[DATA_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* rtl/core/unsorted_table_linear_interp_top.sv */
// Top level of the unsorted-table piecewise linear interpolator.
//
// Usage: an item is taken when start is high and busy is low. A load item
// (in_action low) writes in_point_x and in_point_y to slot in_point_index in the
// accept cycle and yields no result; slots at or beyond TABLE_DEPTH are ignored.
// A query item (in_action high) scans the first active points, finds the nearest
// stored x on each side of in_query_x and returns a signed Q16.16 value with a
// status code on out_result_y and out_status, marked by out_valid for one cycle.
// The receiver cannot stall; each result is shown exactly once.
// Sequence: a load leaves busy low. A query holds busy while it scans the active
// points through the single table read port and then takes a decision state; to
// interpolate it goes on through a multiply state, the divider and a sum state to
// the result state, and to match or clamp it goes from the decision state to the
// result state. The result is shown in the last busy cycle. An empty table goes
// straight to the result state, which carries its result. cfg_wr_data sets the
// number of active points, values above TABLE_DEPTH counting as TABLE_DEPTH; it
// is to be written only while the block is idle, which the block does not enforce.
// Reset clears the control state and the active point count to zero; table
// entries hold nothing defined until they are loaded.
module unsorted_table_linear_interp_top import utli_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_action,
  input  logic [INDEX_W-1:0]         in_point_index,
  input  logic signed [DATA_W-1:0]   in_point_x,
  input  logic signed [DATA_W-1:0]   in_point_y,
  input  logic signed [DATA_W-1:0]   in_query_x,
  output logic                       out_valid,
  output logic signed [DATA_W-1:0]   out_result_y,
  output logic [STATUS_W-1:0]        out_status,
  input  logic                       cfg_wr_en,
  input  logic [ACTIVE_W-1:0]        cfg_wr_data
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_DECIDE = 7'b0000100,
    S_MUL    = 7'b0001000,
    S_DIV    = 7'b0010000,
    S_SUM    = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [ACTIVE_W-1:0]      active_points_r, active_points_nxt;
  logic [CNT_W-1:0]         n_r, n_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     rd_valid_r, rd_valid_nxt;
  logic signed [DATA_W-1:0] q_r, q_nxt;
  logic                     lo_v_r, lo_v_nxt, hi_v_r, hi_v_nxt;
  logic signed [DATA_W-1:0] lo_x_r, lo_x_nxt, lo_y_r, lo_y_nxt;
  logic signed [DATA_W-1:0] hi_x_r, hi_x_nxt, hi_y_r, hi_y_nxt;
  logic [DATA_W-1:0]        dx_r, dx_nxt, span_r, span_nxt, mag_r, mag_nxt;
  logic                     neg_r, neg_nxt;
  logic signed [DATA_W-1:0] res_y_r, res_y_nxt;
  logic [STATUS_W-1:0]      res_stat_r, res_stat_nxt;

  logic                     accept;
  logic                     load_we;
  logic [31:0]              slot_ext;
  logic [31:0]              active_ext;
  logic signed [DATA_W-1:0] rd_x, rd_y;
  logic                     div_done;
  logic [DATA_W-1:0]        div_quo;
  logic [2*DATA_W-1:0]      product;
  logic signed [DATA_W:0]   dx_full, span_full, dy_full;
  logic [DATA_W:0]          mag_full;
  logic signed [DATA_W+1:0] delta, sum;

  assign busy       = (state_r != S_IDLE);
  assign accept     = start && !busy;
  assign slot_ext   = 32'(in_point_index);
  assign active_ext = 32'(active_points_r);
  assign load_we    = accept && (in_action == ACT_LOAD) && (slot_ext < 32'(TABLE_DEPTH));

  utli_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (load_we),
    .wr_addr (slot_ext[ADDR_W-1:0]),
    .wr_x    (in_point_x),
    .wr_y    (in_point_y),
    .rd_addr (cnt_r[ADDR_W-1:0]),
    .rd_x    (rd_x),
    .rd_y    (rd_y)
  );

  // The product is registered inside the divider when it is loaded.
  assign product = dx_r * mag_r;

  utli_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_MUL),
    .dividend (product),
    .divisor  (span_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign dx_full   = {q_r[DATA_W-1], q_r} - {lo_x_r[DATA_W-1], lo_x_r};
  assign span_full = {hi_x_r[DATA_W-1], hi_x_r} - {lo_x_r[DATA_W-1], lo_x_r};
  assign dy_full   = {hi_y_r[DATA_W-1], hi_y_r} - {lo_y_r[DATA_W-1], lo_y_r};
  assign mag_full  = dy_full[DATA_W] ? (DATA_W+1)'(-dy_full) : dy_full;
  assign delta     = neg_r ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
  assign sum       = {{2{lo_y_r[DATA_W-1]}}, lo_y_r} + delta;

  always_comb begin
    state_nxt         = state_r;
    active_points_nxt = active_points_r;
    n_nxt             = n_r;
    cnt_nxt           = cnt_r;
    rd_valid_nxt      = 1'b0;
    q_nxt             = q_r;
    lo_v_nxt          = lo_v_r;
    lo_x_nxt          = lo_x_r;
    lo_y_nxt          = lo_y_r;
    hi_v_nxt          = hi_v_r;
    hi_x_nxt          = hi_x_r;
    hi_y_nxt          = hi_y_r;
    dx_nxt            = dx_r;
    span_nxt          = span_r;
    mag_nxt           = mag_r;
    neg_nxt           = neg_r;
    res_y_nxt         = res_y_r;
    res_stat_nxt      = res_stat_r;

    if (cfg_wr_en) begin
      active_points_nxt = cfg_wr_data;
    end

    case (state_r)
      S_IDLE: begin
        if (accept && (in_action == ACT_QUERY)) begin
          q_nxt    = in_query_x;
          cnt_nxt  = '0;
          lo_v_nxt = 1'b0;
          hi_v_nxt = 1'b0;
          n_nxt    = (active_ext > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                      : CNT_W'(active_ext);
          if (active_points_r == '0) begin
            res_y_nxt    = '0;
            res_stat_nxt = STAT_EMPTY;
            state_nxt    = S_OUT;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // Read data arrives in the cycle after its address; rd_valid_r tracks it.
        if (cnt_r < n_r) begin
          cnt_nxt      = cnt_r + 1'b1;
          rd_valid_nxt = 1'b1;
        end else begin
          state_nxt = S_DECIDE;
        end
        if (rd_valid_r) begin
          if ((rd_x <= q_r) && (!lo_v_r || (rd_x > lo_x_r))) begin
            lo_v_nxt = 1'b1;
            lo_x_nxt = rd_x;
            lo_y_nxt = rd_y;
          end
          if ((rd_x >= q_r) && (!hi_v_r || (rd_x < hi_x_r))) begin
            hi_v_nxt = 1'b1;
            hi_x_nxt = rd_x;
            hi_y_nxt = rd_y;
          end
        end
      end
      S_DECIDE: begin
        dx_nxt   = dx_full[DATA_W-1:0];
        span_nxt = span_full[DATA_W-1:0];
        mag_nxt  = mag_full[DATA_W-1:0];
        neg_nxt  = dy_full[DATA_W];
        if (!lo_v_r) begin
          res_y_nxt    = hi_y_r;
          res_stat_nxt = STAT_BELOW;
          state_nxt    = S_OUT;
        end else if (!hi_v_r) begin
          res_y_nxt    = lo_y_r;
          res_stat_nxt = STAT_ABOVE;
          state_nxt    = S_OUT;
        end else if (lo_x_r == q_r) begin
          res_y_nxt    = lo_y_r;
          res_stat_nxt = STAT_EXACT;
          state_nxt    = S_OUT;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        // Saturate when the two top bits disagree with the sign of the low word.
        if ((sum[DATA_W+1] != sum[DATA_W]) || (sum[DATA_W] != sum[DATA_W-1])) begin
          res_y_nxt = sum[DATA_W+1] ? SAT_MIN : SAT_MAX;
        end else begin
          res_y_nxt = sum[DATA_W-1:0];
        end
        res_stat_nxt = STAT_INTERP;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      active_points_r <= '0;
      n_r             <= '0;
      cnt_r           <= '0;
      rd_valid_r      <= 1'b0;
      lo_v_r          <= 1'b0;
      hi_v_r          <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      active_points_r <= active_points_nxt;
      n_r             <= n_nxt;
      cnt_r           <= cnt_nxt;
      rd_valid_r      <= rd_valid_nxt;
      lo_v_r          <= lo_v_nxt;
      hi_v_r          <= hi_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r        <= q_nxt;
    lo_x_r     <= lo_x_nxt;
    lo_y_r     <= lo_y_nxt;
    hi_x_r     <= hi_x_nxt;
    hi_y_r     <= hi_y_nxt;
    dx_r       <= dx_nxt;
    span_r     <= span_nxt;
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    res_y_r    <= res_y_nxt;
    res_stat_r <= res_stat_nxt;
  end

  assign out_valid    = (state_r == S_OUT);
  assign out_result_y = res_y_r;
  assign out_status   = res_stat_r;

  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STAT_EMPTY)) |-> (out_result_y == '0))
    else $error("empty-table result is not zero");

  a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide state");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (cnt_r <= n_r))
    else $error("scan counter ran past the active point count");

endmodule
